FILE: rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared types, constants and helpers for the size-aware LFU cache policy.
// ----------------------------------------------------------------------------
package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int SIZE_W  = 32;
    localparam int COUNT_W = 32;
    localparam int TIME_W  = 48;
    localparam int EVC_W   = 7;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 3;

    // register index of capacity_bytes (paddr[2])
    localparam logic CAP_REG_IDX = 1'b0;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [COUNT_W-1:0] NEW_COUNT = COUNT_W'(1);
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;
    localparam logic [EVC_W-1:0]   EVC_MAX   = '1;

    // one table entry as stored in the entry memory
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SIZE_W-1:0]  size;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  last_use;
    } entry_t;

    // sequencer to scan unit
    typedef struct packed {
        logic clear;   // start of a new scan
        logic sample;  // read data valid this cycle
        logic evict;   // current victim is being dropped
    } scan_ctl_t;

    // scan unit to sequencer
    typedef struct packed {
        logic match_found;
        logic free_found;
        logic victim_found;
    } scan_stat_t;

    function automatic logic [TIME_W-1:0] sat_inc48(input logic [TIME_W-1:0] v);
        return (v == TIME_MAX) ? v : v + TIME_W'(1);
    endfunction

endpackage

FILE: rtl/lfu_entry_mem.sv
// ----------------------------------------------------------------------------
// lfu_entry_mem
// Entry table storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lfu_entry_mem
    import lfu_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lfu_scan_unit.sv
// ----------------------------------------------------------------------------
// lfu_scan_unit
// Shared compare unit: checks one entry per cycle for key match, first free
// slot and best victim (lowest count, then oldest last use, then lowest slot).
// ----------------------------------------------------------------------------
module lfu_scan_unit
    import lfu_pkg::*;
#(
    parameter int AW = 6
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  scan_ctl_t          ctl,
    input  logic [AW-1:0]      rd_idx,
    input  logic               rd_valid,
    input  entry_t             rd_entry,
    input  logic [KEY_W-1:0]   key,
    output scan_stat_t         stat,
    output logic [AW-1:0]      match_idx,
    output logic [COUNT_W-1:0] match_count,
    output logic [SIZE_W-1:0]  match_size,
    output logic [AW-1:0]      free_idx,
    output logic [AW-1:0]      victim_idx,
    output logic [SIZE_W-1:0]  victim_size
);

    scan_stat_t         stat_reg, stat_next;
    logic [AW-1:0]      match_idx_reg, match_idx_next;
    logic [COUNT_W-1:0] match_count_reg, match_count_next;
    logic [SIZE_W-1:0]  match_size_reg, match_size_next;
    logic [AW-1:0]      free_idx_reg, free_idx_next;
    logic [AW-1:0]      victim_idx_reg, victim_idx_next;
    logic [SIZE_W-1:0]  victim_size_reg, victim_size_next;
    logic [COUNT_W-1:0] victim_count_reg, victim_count_next;
    logic [TIME_W-1:0]  victim_last_reg, victim_last_next;
    logic               better;

    // victim order: strictly lower count, or equal count and older
    assign better = (rd_entry.count < victim_count_reg) ||
                    ((rd_entry.count == victim_count_reg) &&
                     (rd_entry.last_use < victim_last_reg));

    always_comb begin
        stat_next         = stat_reg;
        match_idx_next    = match_idx_reg;
        match_count_next  = match_count_reg;
        match_size_next   = match_size_reg;
        free_idx_next     = free_idx_reg;
        victim_idx_next   = victim_idx_reg;
        victim_size_next  = victim_size_reg;
        victim_count_next = victim_count_reg;
        victim_last_next  = victim_last_reg;
        if (ctl.clear) begin
            stat_next = '0;
        end else if (ctl.sample) begin
            if (rd_valid) begin
                if (!stat_reg.match_found && rd_entry.key == key) begin
                    stat_next.match_found = 1'b1;
                    match_idx_next        = rd_idx;
                    match_count_next      = rd_entry.count;
                    match_size_next       = rd_entry.size;
                end
                if (!stat_reg.victim_found || better) begin
                    stat_next.victim_found = 1'b1;
                    victim_idx_next        = rd_idx;
                    victim_size_next       = rd_entry.size;
                    victim_count_next      = rd_entry.count;
                    victim_last_next       = rd_entry.last_use;
                end
            end else if (!stat_reg.free_found) begin
                stat_next.free_found = 1'b1;
                free_idx_next        = rd_idx;
            end
        end else if (ctl.evict) begin
            // the dropped slot becomes free; keep the lowest free slot
            stat_next.free_found   = 1'b1;
            stat_next.victim_found = 1'b0;
            if (!stat_reg.free_found || victim_idx_reg < free_idx_reg) begin
                free_idx_next = victim_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stat_reg <= '0;
        end else begin
            stat_reg <= stat_next;
        end
    end

    always_ff @(posedge aclk) begin
        match_idx_reg    <= match_idx_next;
        match_count_reg  <= match_count_next;
        match_size_reg   <= match_size_next;
        free_idx_reg     <= free_idx_next;
        victim_idx_reg   <= victim_idx_next;
        victim_size_reg  <= victim_size_next;
        victim_count_reg <= victim_count_next;
        victim_last_reg  <= victim_last_next;
    end

    assign stat        = stat_reg;
    assign match_idx   = match_idx_reg;
    assign match_count = match_count_reg;
    assign match_size  = match_size_reg;
    assign free_idx    = free_idx_reg;
    assign victim_idx  = victim_idx_reg;
    assign victim_size = victim_size_reg;

endmodule

FILE: rtl/size_aware_lfu_cache_policy.sv
// ----------------------------------------------------------------------------
// size_aware_lfu_cache_policy
// Byte-capacity LFU replacement policy with a sequenced table scan.
// ----------------------------------------------------------------------------
// Each access word is handled one at a time. The table lives in a single-port
// read memory that is walked one entry per cycle through one compare unit;
// a hit or a bypass then passes through a decision state and a state that
// posts the result. A miss that fits needs no more. Each eviction is made in
// the decision state, and if the object still does not fit, another full
// scan finds the next victim. A result still held off by m_ready delays the
// posting of the next one.
// s_ready is high only while no access is in progress; a result
// waiting in the output register does not hold off the next access word.
// capacity_bytes sits at byte address 0 of the APB port and resets to zero.
// ----------------------------------------------------------------------------
module size_aware_lfu_cache_policy
    import lfu_pkg::*;
#(
    parameter int ENTRIES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    // config port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    // access channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [KEY_W-1:0]    s_access_key,
    input  logic [SIZE_W-1:0]   s_object_size,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_hit,
    output logic                m_bypassed,
    output logic [EVC_W-1:0]    m_evicted_count,
    output logic [SIZE_W-1:0]   m_bytes_in_use,
    output logic [TIME_W-1:0]   m_total_accesses,
    output logic [TIME_W-1:0]   m_hit_accesses
);

    localparam int            IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW:0]   ENT_CNT = (IW+1)'(ENTRIES);
    localparam logic [IW-1:0] LAST_IX = IW'(ENTRIES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_DONE   = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic               lookup_reg, lookup_next;
    logic               fresh_reg, fresh_next;
    logic [IW:0]        iss_reg, iss_next;
    logic               rd_vld_reg, rd_vld_next;
    logic [IW-1:0]      rd_idx_reg, rd_idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [SIZE_W-1:0]  res_reg, res_next;
    logic [SIZE_W-1:0]  cap_reg, cap_next;
    logic [TIME_W-1:0]  clock_reg, clock_next;
    logic [TIME_W-1:0]  total_reg, total_next;
    logic [TIME_W-1:0]  hitc_reg, hitc_next;
    logic               hit_f_reg, hit_f_next;
    logic               byp_f_reg, byp_f_next;
    logic [EVC_W-1:0]   evc_reg, evc_next;
    logic               m_valid_reg, m_valid_next;
    logic [KEY_W-1:0]   key_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic               out_load;

    logic               m_hit_reg, m_byp_reg;
    logic [EVC_W-1:0]   m_evc_reg;
    logic [SIZE_W-1:0]  m_bytes_reg;
    logic [TIME_W-1:0]  m_total_reg, m_hitc_reg;

    // memory and scan unit hookup
    logic               mem_we, mem_re;
    logic [IW-1:0]      mem_waddr, mem_raddr;
    entry_t             mem_wdata, mem_rdata;
    scan_ctl_t          scan_ctl;
    scan_stat_t         scan_stat;
    logic [IW-1:0]      match_idx, free_idx, victim_idx;
    logic [COUNT_W-1:0] match_count;
    logic [SIZE_W-1:0]  match_size, victim_size;

    logic               s_acc, cfg_wr, fits, do_insert;
    logic [SIZE_W:0]    need_sum;

    lfu_entry_mem #(.DEPTH(ENTRIES), .AW(IW)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lfu_scan_unit #(.AW(IW)) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (scan_ctl),
        .rd_idx      (rd_idx_reg),
        .rd_valid    (valid_reg[rd_idx_reg]),
        .rd_entry    (mem_rdata),
        .key         (key_reg),
        .stat        (scan_stat),
        .match_idx   (match_idx),
        .match_count (match_count),
        .match_size  (match_size),
        .free_idx    (free_idx),
        .victim_idx  (victim_idx),
        .victim_size (victim_size)
    );

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == CAP_REG_IDX) ? cap_reg : '0;

    // no word is taken while reset is held
    assign s_ready = aresetn && (state_reg == ST_IDLE);
    assign s_acc   = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // byte fit check for the pending object
    assign need_sum = {1'b0, res_reg} + {1'b0, size_reg};
    assign fits     = (need_sum <= {1'b0, cap_reg}) && scan_stat.free_found;

    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        lookup_next  = lookup_reg;
        fresh_next   = fresh_reg;
        iss_next     = iss_reg;
        rd_vld_next  = 1'b0;
        rd_idx_next  = rd_idx_reg;
        valid_next   = valid_reg;
        res_next     = res_reg;
        cap_next     = cap_reg;
        clock_next   = clock_reg;
        total_next   = total_reg;
        hitc_next    = hitc_reg;
        hit_f_next   = hit_f_reg;
        byp_f_next   = byp_f_reg;
        evc_next     = evc_reg;
        m_valid_next = m_valid_reg;
        mem_we       = 1'b0;
        mem_waddr    = free_idx;
        mem_wdata    = '{key: key_reg, size: size_reg, count: NEW_COUNT,
                         last_use: clock_reg};
        mem_re       = 1'b0;
        mem_raddr    = iss_reg[IW-1:0];
        scan_ctl     = '0;
        do_insert    = 1'b0;

        if (cfg_wr && paddr[2] == CAP_REG_IDX) begin
            cap_next = pwdata;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    clock_next     = sat_inc48(clock_reg);
                    total_next     = sat_inc48(total_reg);
                    hit_f_next     = 1'b0;
                    byp_f_next     = 1'b0;
                    evc_next       = '0;
                    lookup_next    = 1'b1;
                    iss_next       = '0;
                    scan_ctl.clear = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // issue one read per cycle, evaluate it the next
                if (iss_reg < ENT_CNT) begin
                    mem_re      = 1'b1;
                    rd_vld_next = 1'b1;
                    rd_idx_next = iss_reg[IW-1:0];
                    iss_next    = iss_reg + (IW+1)'(1);
                end
                scan_ctl.sample = rd_vld_reg;
                if (rd_vld_reg && rd_idx_reg == LAST_IX) begin
                    fresh_next = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (lookup_reg && scan_stat.match_found) begin
                    // hit: bump count and refresh last use
                    mem_we     = 1'b1;
                    mem_waddr  = match_idx;
                    mem_wdata  = '{key: key_reg, size: match_size,
                                   count: (match_count == COUNT_MAX) ? match_count
                                          : match_count + COUNT_W'(1),
                                   last_use: clock_reg};
                    hitc_next  = sat_inc48(hitc_reg);
                    hit_f_next = 1'b1;
                    state_next = ST_DONE;
                end else if (lookup_reg && size_reg > cap_reg) begin
                    byp_f_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    lookup_next = 1'b0;
                    if (fits) begin
                        do_insert = 1'b1;
                    end else if (fresh_reg) begin
                        if (scan_stat.victim_found) begin
                            // drop the victim and check again
                            valid_next[victim_idx] = 1'b0;
                            res_next       = res_reg - victim_size;
                            evc_next       = (evc_reg == EVC_MAX) ? evc_reg
                                             : evc_reg + EVC_W'(1);
                            scan_ctl.evict = 1'b1;
                            fresh_next     = 1'b0;
                        end else begin
                            do_insert = 1'b1;
                        end
                    end else begin
                        // victim used up: rescan for the next one
                        scan_ctl.clear = 1'b1;
                        iss_next       = '0;
                        state_next     = ST_SCAN;
                    end
                    if (do_insert) begin
                        if (scan_stat.free_found) begin
                            mem_we               = 1'b1;
                            valid_next[free_idx] = 1'b1;
                            res_next             = res_reg + size_reg;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lookup_reg  <= 1'b0;
            fresh_reg   <= 1'b0;
            iss_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            valid_reg   <= '0;
            res_reg     <= '0;
            cap_reg     <= '0;
            clock_reg   <= '0;
            total_reg   <= '0;
            hitc_reg    <= '0;
            hit_f_reg   <= 1'b0;
            byp_f_reg   <= 1'b0;
            evc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lookup_reg  <= lookup_next;
            fresh_reg   <= fresh_next;
            iss_reg     <= iss_next;
            rd_vld_reg  <= rd_vld_next;
            valid_reg   <= valid_next;
            res_reg     <= res_next;
            cap_reg     <= cap_next;
            clock_reg   <= clock_next;
            total_reg   <= total_next;
            hitc_reg    <= hitc_next;
            hit_f_reg   <= hit_f_next;
            byp_f_reg   <= byp_f_next;
            evc_reg     <= evc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rd_idx_reg <= rd_idx_next;
        if (s_acc) begin
            key_reg  <= s_access_key;
            size_reg <= s_object_size;
        end
        if (out_load) begin
            m_hit_reg   <= hit_f_reg;
            m_byp_reg   <= byp_f_reg;
            m_evc_reg   <= evc_reg;
            m_bytes_reg <= res_reg;
            m_total_reg <= total_reg;
            m_hitc_reg  <= hitc_reg;
        end
    end

    assign m_hit            = m_hit_reg;
    assign m_bypassed       = m_byp_reg;
    assign m_evicted_count  = m_evc_reg;
    assign m_bytes_in_use   = m_bytes_reg;
    assign m_total_accesses = m_total_reg;
    assign m_hit_accesses   = m_hitc_reg;

`ifndef SYNTH
    // table is never written while it is being walked
    a_scan_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |-> !mem_we)
        else $error("entry write during scan");

    // a hit neither bypasses nor evicts
    a_hit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_hit_reg |-> !m_byp_reg && m_evc_reg == '0)
        else $error("hit result with bypass or eviction");

    // an accepted word always starts a table scan
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> state_reg == ST_SCAN)
        else $error("accepted word did not start a scan");

    // an insert never leaves more bytes resident than the capacity
    a_insert_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert && mem_we |=> res_reg <= cap_reg)
        else $error("insert overran capacity");
`endif

endmodule
